>>> design/rdss_pkg.sv
// Shared widths, codes and header constants for the RDSS frame receiver.
// Used by the channel interfaces and by the top level; depends on nothing.
package rdss_pkg;

   localparam int BYTE_WIDTH   = 8;
   localparam int POS_WIDTH    = 5;
   localparam int CARD_WIDTH   = 24;
   localparam int FREQ_WIDTH   = 16;
   localparam int KIND_WIDTH   = 3;
   localparam int STATUS_WIDTH = 2;
   localparam int LEVEL_WIDTH  = 3;

   localparam int HEADER_LEN = 5;
   localparam int CARD_LEN   = 3;
   localparam int TAIL_LEN   = 6;

   localparam logic [POS_WIDTH-1:0] POS_MAX        = 5'd31;
   localparam logic [POS_WIDTH-1:0] POS_MIN_FRAME  = 5'd4;
   localparam logic [POS_WIDTH-1:0] POS_CARD_FIRST = 5'd7;
   localparam logic [POS_WIDTH-1:0] POS_CARD_LAST  = 5'd9;
   localparam logic [POS_WIDTH-1:0] POS_TAIL_FIRST = 5'd14;
   localparam logic [POS_WIDTH-1:0] POS_TAIL_LAST  = 5'd19;

   // Header is "$" + three letters + "X".
   localparam logic [BYTE_WIDTH-1:0] HDR_LEAD  = 8'h24;
   localparam logic [BYTE_WIDTH-1:0] HDR_CLOSE = 8'h58;
   localparam logic [BYTE_WIDTH-1:0] HDR_Z     = 8'h5A;
   localparam logic [BYTE_WIDTH-1:0] HDR_J     = 8'h4A;
   localparam logic [BYTE_WIDTH-1:0] HDR_X     = 8'h58;
   localparam logic [BYTE_WIDTH-1:0] HDR_I     = 8'h49;
   localparam logic [BYTE_WIDTH-1:0] HDR_C     = 8'h43;
   localparam logic [BYTE_WIDTH-1:0] HDR_F     = 8'h46;
   localparam logic [BYTE_WIDTH-1:0] HDR_K     = 8'h4B;
   localparam logic [BYTE_WIDTH-1:0] HDR_T     = 8'h54;

   // Card pattern 1F FF FF means "no card" and clears the stored values.
   localparam logic [BYTE_WIDTH-1:0] CARD_CLEAR_HI = 8'h1F;
   localparam logic [BYTE_WIDTH-1:0] CARD_CLEAR_LO = 8'hFF;

   localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = 3'd4;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_UNKNOWN    = 3'd0,
      KIND_SELF_CHECK = 3'd1,
      KIND_CARD_INFO  = 3'd2,
      KIND_FEEDBACK   = 3'd3,
      KIND_MESSAGE    = 3'd4
   } frame_kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_ACCEPTED     = 2'd0,
      STATUS_BAD_CHECKSUM = 2'd1,
      STATUS_SHORT        = 2'd2
   } frame_status_type;

endpackage

>>> design/rdss_if.sv
// Valid/ready channel interfaces for the RDSS frame receiver: received bytes
// in, frame results out. Depends on rdss_pkg for field widths.
interface rdss_req_if import rdss_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] rx_byte;
   logic                  last_byte;
   logic                  module_powered;

   modport source (output valid, output rx_byte, output last_byte,
                   output module_powered, input ready);
   modport sink   (input valid, input rx_byte, input last_byte,
                   input module_powered, output ready);
endinterface

interface rdss_rsp_if import rdss_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [KIND_WIDTH-1:0]   frame_kind;
   logic [STATUS_WIDTH-1:0] frame_status;
   logic [CARD_WIDTH-1:0]   check_card_number;
   logic [CARD_WIDTH-1:0]   info_card_number;
   logic [FREQ_WIDTH-1:0]   info_frequency;
   logic [LEVEL_WIDTH-1:0]  signal_level;

   modport source (output valid, output frame_kind, output frame_status,
                   output check_card_number, output info_card_number,
                   output info_frequency, output signal_level, input ready);
   modport sink   (input valid, input frame_kind, input frame_status,
                   input check_card_number, input info_card_number,
                   input info_frequency, input signal_level, output ready);
endinterface

>>> design/rdss_frame_receiver_unit.sv
// Top level of the RDSS frame receiver: byte capture, frame check and result.
// Depends on rdss_pkg and the channel interfaces in rdss_if.sv.
//
// Usage: bytes arrive on req_chan, one per transfer, with last_byte set on
// the checksum byte that closes a frame. Every byte is held in an input
// register and then folded into the frame state (XOR, position,
// captured header, card and tail bytes). The closing byte produces one result
// on rsp_chan: frame kind, status, the stored card numbers, frequency and the
// signal level taken from the six stored beam powers. Other bytes give none.
// The closing byte passes the input register, then the result register, which
// raises rsp valid. Throughput is one byte per cycle unless a closing byte
// waits on a stalled rsp_chan; the result register lets a new frame start while
// an earlier result is still waiting. When rsp_chan stalls, a closing byte waits
// in the input register and req_chan ready drops; bytes inside a frame still
// pass. Reset clears the frame state, stored card data and both valid flags.
module rdss_frame_receiver_unit import rdss_pkg::*; (
   input logic      clock,
   input logic      reset,
   rdss_req_if.sink   req_chan,
   rdss_rsp_if.source rsp_chan
);

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_WIDTH-1:0] in_byte_ff;
   logic                  in_last_ff;
   logic                  in_powered_ff;

   // Frame state.
   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [BYTE_WIDTH-1:0] xor_ff, xor_in;
   logic [BYTE_WIDTH-1:0] header_ff [HEADER_LEN];
   logic [BYTE_WIDTH-1:0] card_ff   [CARD_LEN];
   logic [BYTE_WIDTH-1:0] tail_ff   [TAIL_LEN];

   // Stored card data.
   logic [CARD_WIDTH-1:0] check_card_ff, check_card_in;
   logic [CARD_WIDTH-1:0] info_card_ff, info_card_in;
   logic [FREQ_WIDTH-1:0] freq_ff, freq_in;
   logic [BYTE_WIDTH-1:0] power_ff [TAIL_LEN];
   logic [BYTE_WIDTH-1:0] power_in [TAIL_LEN];

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   frame_kind_type         rsp_kind_ff, kind_in;
   frame_status_type       rsp_status_ff, status_in;
   logic [LEVEL_WIDTH-1:0] rsp_level_ff, level_in;

   // Frame view with the current byte placed at its offset.
   logic [BYTE_WIDTH-1:0] header_cur [HEADER_LEN];
   logic [BYTE_WIDTH-1:0] card_cur   [CARD_LEN];
   logic [BYTE_WIDTH-1:0] tail_cur   [TAIL_LEN];

   logic                  out_free;
   logic                  advance;
   logic                  end_frame;
   logic                  in_header, in_card, in_tail;
   logic [POS_WIDTH-1:0]  card_off, tail_off;
   logic                  head_ok, card_clear;
   logic [CARD_WIDTH-1:0] card_value;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign end_frame = advance && in_last_ff;

   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in    = req_chan.valid ? 1'b1 : (in_valid_ff && !advance);

   assign in_header = pos_ff < POS_WIDTH'(HEADER_LEN);
   assign in_card   = (pos_ff >= POS_CARD_FIRST) && (pos_ff <= POS_CARD_LAST);
   assign in_tail   = (pos_ff >= POS_TAIL_FIRST) && (pos_ff <= POS_TAIL_LAST);
   assign card_off  = pos_ff - POS_CARD_FIRST;
   assign tail_off  = pos_ff - POS_TAIL_FIRST;

   always_comb begin
      for (int i = 0; i < HEADER_LEN; i++) begin
         header_cur[i] = (in_header && pos_ff[2:0] == 3'(i)) ? in_byte_ff : header_ff[i];
      end
      for (int i = 0; i < CARD_LEN; i++) begin
         card_cur[i] = (in_card && card_off[1:0] == 2'(i)) ? in_byte_ff : card_ff[i];
      end
      for (int i = 0; i < TAIL_LEN; i++) begin
         tail_cur[i] = (in_tail && tail_off[2:0] == 3'(i)) ? in_byte_ff : tail_ff[i];
      end
   end

   assign head_ok    = (header_cur[0] == HDR_LEAD) && (header_cur[4] == HDR_CLOSE);
   assign card_value = {card_cur[0], card_cur[1], card_cur[2]};
   assign card_clear = (card_cur[0] == CARD_CLEAR_HI) && (card_cur[1] == CARD_CLEAR_LO)
                       && (card_cur[2] == CARD_CLEAR_LO);

   // Frame check, classification and stored data update.
   always_comb begin
      kind_in       = KIND_UNKNOWN;
      status_in     = STATUS_ACCEPTED;
      check_card_in = check_card_ff;
      info_card_in  = info_card_ff;
      freq_in       = freq_ff;
      for (int i = 0; i < TAIL_LEN; i++) begin
         power_in[i] = power_ff[i];
      end
      if (pos_ff < POS_MIN_FRAME) begin
         status_in = STATUS_SHORT;
      end else if (xor_ff != in_byte_ff) begin
         status_in = STATUS_BAD_CHECKSUM;
      end else if (head_ok) begin
         if (header_cur[1] == HDR_Z && header_cur[2] == HDR_J && header_cur[3] == HDR_X) begin
            kind_in       = KIND_SELF_CHECK;
            check_card_in = card_clear ? '0 : card_value;
            for (int i = 0; i < TAIL_LEN; i++) begin
               power_in[i] = card_clear ? '0 : tail_cur[i];
            end
         end else if (header_cur[1] == HDR_I && header_cur[2] == HDR_C
                      && header_cur[3] == HDR_X) begin
            kind_in      = KIND_CARD_INFO;
            info_card_in = card_clear ? '0 : card_value;
            freq_in      = card_clear ? '0 : {tail_cur[1], tail_cur[2]};
         end else if (header_cur[1] == HDR_F && header_cur[2] == HDR_K
                      && header_cur[3] == HDR_X) begin
            kind_in = KIND_FEEDBACK;
         end else if (header_cur[1] == HDR_T && header_cur[2] == HDR_X
                      && header_cur[3] == HDR_X) begin
            kind_in = KIND_MESSAGE;
         end
      end
   end

   // Signal level is the largest stored power that lies in 1..4, or zero if none does or the module is unpowered.
   always_comb begin
      level_in = '0;
      if (in_powered_ff) begin
         for (int i = 0; i < TAIL_LEN; i++) begin
            if (power_in[i] != '0 && power_in[i] <= BYTE_WIDTH'(LEVEL_MAX)
                && power_in[i][LEVEL_WIDTH-1:0] > level_in) begin
               level_in = power_in[i][LEVEL_WIDTH-1:0];
            end
         end
      end
   end

   assign pos_in       = end_frame ? '0 : ((pos_ff == POS_MAX) ? POS_MAX : pos_ff + 1'b1);
   assign xor_in       = end_frame ? '0 : (xor_ff ^ in_byte_ff);
   assign rsp_valid_in = end_frame ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_byte_ff    <= req_chan.rx_byte;
         in_last_ff    <= req_chan.last_byte;
         in_powered_ff <= req_chan.module_powered;
      end
      if (end_frame) begin
         rsp_kind_ff   <= kind_in;
         rsp_status_ff <= status_in;
         rsp_level_ff  <= level_in;
      end
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= '0;
         xor_ff        <= '0;
         check_card_ff <= '0;
         info_card_ff  <= '0;
         freq_ff       <= '0;
         for (int i = 0; i < HEADER_LEN; i++) header_ff[i] <= '0;
         for (int i = 0; i < CARD_LEN; i++) card_ff[i] <= '0;
         for (int i = 0; i < TAIL_LEN; i++) begin
            tail_ff[i]  <= '0;
            power_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            pos_ff <= pos_in;
            xor_ff <= xor_in;
            for (int i = 0; i < HEADER_LEN; i++) begin
               header_ff[i] <= end_frame ? '0 : header_cur[i];
            end
            for (int i = 0; i < CARD_LEN; i++) begin
               card_ff[i] <= end_frame ? '0 : card_cur[i];
            end
            for (int i = 0; i < TAIL_LEN; i++) begin
               tail_ff[i] <= end_frame ? '0 : tail_cur[i];
            end
         end
         if (end_frame) begin
            check_card_ff <= check_card_in;
            info_card_ff  <= info_card_in;
            freq_ff       <= freq_in;
            for (int i = 0; i < TAIL_LEN; i++) power_ff[i] <= power_in[i];
         end
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.frame_kind        = rsp_kind_ff;
   assign rsp_chan.frame_status      = rsp_status_ff;
   assign rsp_chan.check_card_number = check_card_ff;
   assign rsp_chan.info_card_number  = info_card_ff;
   assign rsp_chan.info_frequency    = freq_ff;
   assign rsp_chan.signal_level      = rsp_level_ff;

   // A recognized kind only comes from a frame that passed its checks.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_UNKNOWN |-> rsp_status_ff == STATUS_ACCEPTED)
      else $error("frame kind reported on a rejected frame");

   // Closing a frame returns the position and the XOR to zero.
   assert property (@(posedge clock) disable iff (reset)
      end_frame |=> pos_ff == '0 && xor_ff == '0)
      else $error("frame state not cleared after closing byte");

   // A closing byte never overwrites a result that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !end_frame)
      else $error("result overwritten while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_level_ff <= LEVEL_MAX)
      else $error("signal level out of range");

endmodule
